/* rtl/core/cc_cv_charger_pi_regulator_macros.svh */
// Assertion macros for the CC/CV charger regulator checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef CC_CV_CHARGER_PI_REGULATOR_MACROS_SVH
`define CC_CV_CHARGER_PI_REGULATOR_MACROS_SVH

// Check a property on the rising clock, skipped while reset is asserted.
`define CCCVPI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a property on the rising clock, also evaluated during reset.
`define CCCVPI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/cccvpi_pkg.sv */
// Shared types, constants and helpers for the CC/CV charger PI regulator.
// No dependencies; used by the datapath, the top level and the checker.
package cccvpi_pkg;

  localparam int SAMPLE_BITS    = 12;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int GAIN_W         = 16;
  localparam int DRIVE_W        = 16;
  localparam int MODE_W         = 2;

  // error is target minus sample, one bit wider than a sample
  localparam int ERR_W     = SAMPLE_BITS + 1;
  localparam int INT_SUM_W = ((DRIVE_W > ERR_W) ? DRIVE_W : ERR_W) + 1;
  localparam int KP_W      = GAIN_W + 1 + ERR_W;
  localparam int ACC_W     = GAIN_W + DRIVE_W + 2;
  localparam int SH_W      = ACC_W - GAIN_FRAC_BITS;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = ((2 * SAMPLE_BITS + 1 + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DRIVE_W + MODE_W + 7) / 8) * 8;

  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_CURRENT_TARGET = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_VOLTAGE_TARGET = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_CUTOFF_CURRENT = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_KP_GAIN        = CFG_ADDR_W'(3);
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_KI_T_GAIN      = CFG_ADDR_W'(4);
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_DRIVE_MAX      = CFG_ADDR_W'(5);
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_DRIVE_MIN      = CFG_ADDR_W'(6);

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE = 2'd0,
    MODE_CC   = 2'd1,
    MODE_CV   = 2'd2
  } mode_t;

  typedef struct packed {
    logic        [SAMPLE_BITS-1:0] current_target;
    logic        [SAMPLE_BITS-1:0] voltage_target;
    logic        [SAMPLE_BITS-1:0] cutoff_current;
    logic        [GAIN_W-1:0]      kp_gain;
    logic        [GAIN_W-1:0]      ki_t_gain;
    logic signed [DRIVE_W-1:0]     drive_max;
    logic signed [DRIVE_W-1:0]     drive_min;
  } cfg_t;

  // Upper limit is tested first and wins where both apply when the limits cross.
  function automatic logic signed [DRIVE_W-1:0] clamp_drive(
    input logic signed [SH_W-1:0]    v,
    input logic signed [DRIVE_W-1:0] hi,
    input logic signed [DRIVE_W-1:0] lo
  );
    logic signed [DRIVE_W-1:0] res;
    if (v >= SH_W'(hi)) begin
      res = hi;
    end else if (v <= SH_W'(lo)) begin
      res = lo;
    end else begin
      res = v[DRIVE_W-1:0];
    end
    return res;
  endfunction

endpackage

/* rtl/core/cccvpi_datapath.sv */
// One control step of the CC/CV regulator: mode switch and PI update.
// Purely combinational; depends on cccvpi_pkg.
module cccvpi_datapath (
  input  cccvpi_pkg::cfg_t                         cfg,
  input  cccvpi_pkg::mode_t                        mode_cur,
  input  logic signed [cccvpi_pkg::DRIVE_W-1:0]    integ_cur,
  input  logic signed [cccvpi_pkg::DRIVE_W-1:0]    drive_cur,
  input  logic        [cccvpi_pkg::SAMPLE_BITS-1:0] isamp,
  input  logic        [cccvpi_pkg::SAMPLE_BITS-1:0] vsamp,
  input  logic                                     en,
  output cccvpi_pkg::mode_t                        mode_new,
  output logic signed [cccvpi_pkg::DRIVE_W-1:0]    integ_new,
  output logic signed [cccvpi_pkg::DRIVE_W-1:0]    drive_new
);

  logic signed [cccvpi_pkg::ERR_W-1:0]     err_cc;
  logic signed [cccvpi_pkg::ERR_W-1:0]     err_cv;
  logic signed [cccvpi_pkg::ERR_W-1:0]     err;
  logic                                    do_pi;
  logic signed [cccvpi_pkg::INT_SUM_W-1:0] integ_sum;
  logic signed [cccvpi_pkg::DRIVE_W-1:0]   integ_clamped;
  logic signed [cccvpi_pkg::KP_W-1:0]      kp_term;
  logic signed [cccvpi_pkg::ACC_W-1:0]     ki_term;
  logic signed [cccvpi_pkg::ACC_W-1:0]     acc;
  logic signed [cccvpi_pkg::SH_W-1:0]      acc_sh;
  logic signed [cccvpi_pkg::DRIVE_W-1:0]   drive_clamped;

  assign err_cc = signed'({1'b0, cfg.current_target}) - signed'({1'b0, isamp});
  assign err_cv = signed'({1'b0, cfg.voltage_target}) - signed'({1'b0, vsamp});

  // Mode switch uses the mode at the start of the step; the PI update
  // regulates the quantity of that starting mode.
  always_comb begin
    mode_new = cccvpi_pkg::MODE_IDLE;
    err      = err_cc;
    do_pi    = 1'b0;
    case (mode_cur)
      cccvpi_pkg::MODE_IDLE: begin
        mode_new = en ? cccvpi_pkg::MODE_CC : cccvpi_pkg::MODE_IDLE;
      end
      cccvpi_pkg::MODE_CC: begin
        mode_new = (vsamp >= cfg.voltage_target) ? cccvpi_pkg::MODE_CV : cccvpi_pkg::MODE_CC;
        err      = err_cc;
        do_pi    = 1'b1;
      end
      cccvpi_pkg::MODE_CV: begin
        mode_new = (isamp <= cfg.cutoff_current) ? cccvpi_pkg::MODE_IDLE : cccvpi_pkg::MODE_CV;
        err      = err_cv;
        do_pi    = 1'b1;
      end
      default: begin
        mode_new = cccvpi_pkg::MODE_IDLE;
      end
    endcase
  end

  assign integ_sum     = cccvpi_pkg::INT_SUM_W'(integ_cur) + cccvpi_pkg::INT_SUM_W'(err);
  assign integ_clamped = cccvpi_pkg::clamp_drive(cccvpi_pkg::SH_W'(integ_sum),
                                                 cfg.drive_max, cfg.drive_min);

  assign kp_term = cccvpi_pkg::KP_W'(signed'({1'b0, cfg.kp_gain})) * cccvpi_pkg::KP_W'(err);
  assign ki_term = cccvpi_pkg::ACC_W'(signed'({1'b0, cfg.ki_t_gain}))
                 * cccvpi_pkg::ACC_W'(integ_clamped);
  assign acc     = cccvpi_pkg::ACC_W'(kp_term) + ki_term;

  // arithmetic drop of the fraction bits rounds toward minus infinity
  assign acc_sh        = acc[cccvpi_pkg::ACC_W-1:cccvpi_pkg::GAIN_FRAC_BITS];
  assign drive_clamped = cccvpi_pkg::clamp_drive(acc_sh, cfg.drive_max, cfg.drive_min);

  assign integ_new = do_pi ? integ_clamped : integ_cur;
  assign drive_new = do_pi ? drive_clamped : drive_cur;

endmodule

/* rtl/core/cc_cv_charger_pi_regulator.sv */
// Top level of the CC/CV battery charger PI regulator.
// Depends on cccvpi_pkg and cccvpi_datapath.
//
//  channel | direction | payload                          | accepted when
//  --------+-----------+----------------------------------+------------------------
//  in_     | sink      | current, voltage, enable         | in_tvalid & in_tready
//  out_    | source    | drive, mode                      | out_tvalid & out_tready
//  cfg_    | sink      | register index, write data       | cfg_we
//
// Each sample is held in the input register, then one control step
// (mode switch, integrator, two gain multiplies, clamps) runs
// combinationally into the result register, one sample per cycle while
// the output is not stalled. The loop state updates at the same edge
// that loads the result, so the next sample always sees it. A stalled
// output holds its result and the input register, and in_tready drops
// only once both are full. Synchronous active-low reset clears mode,
// integrator, drive and config to their defaults.
module cc_cv_charger_pi_regulator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [11:0] current_sample, [23:12] voltage_sample, [24] enable, rest zero
  input  logic [cccvpi_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [15:0] drive (signed), [17:16] mode, rest zero
  output logic [cccvpi_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                  cfg_we,
  input  logic [cccvpi_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [cccvpi_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int SB = cccvpi_pkg::SAMPLE_BITS;

  // configuration registers
  cccvpi_pkg::cfg_t cfg_r;

  // input register
  logic          in_valid_r;
  logic [SB-1:0] isamp_r;
  logic [SB-1:0] vsamp_r;
  logic          en_r;

  // loop state
  cccvpi_pkg::mode_t                     mode_r;
  logic signed [cccvpi_pkg::DRIVE_W-1:0] integ_r;
  logic signed [cccvpi_pkg::DRIVE_W-1:0] last_drive_r;

  // result register
  logic                                  out_valid_r;
  logic signed [cccvpi_pkg::DRIVE_W-1:0] out_drive_r;
  cccvpi_pkg::mode_t                     out_mode_r;

  cccvpi_pkg::mode_t                     mode_nxt;
  logic signed [cccvpi_pkg::DRIVE_W-1:0] integ_nxt;
  logic signed [cccvpi_pkg::DRIVE_W-1:0] drive_nxt;

  logic advance;
  logic step;

  // the result register frees up when empty or its transfer completes
  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // config writes land directly; the user must issue them only while idle, unchecked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_target <= '0;
      cfg_r.voltage_target <= '1;
      cfg_r.cutoff_current <= '0;
      cfg_r.kp_gain        <= '0;
      cfg_r.ki_t_gain      <= '0;
      cfg_r.drive_max      <= {1'b0, {(cccvpi_pkg::DRIVE_W-1){1'b1}}};
      cfg_r.drive_min      <= {1'b1, {(cccvpi_pkg::DRIVE_W-1){1'b0}}};
    end else if (cfg_we) begin
      case (cfg_addr)
        cccvpi_pkg::CFG_IDX_CURRENT_TARGET: cfg_r.current_target <= cfg_wdata[SB-1:0];
        cccvpi_pkg::CFG_IDX_VOLTAGE_TARGET: cfg_r.voltage_target <= cfg_wdata[SB-1:0];
        cccvpi_pkg::CFG_IDX_CUTOFF_CURRENT: cfg_r.cutoff_current <= cfg_wdata[SB-1:0];
        cccvpi_pkg::CFG_IDX_KP_GAIN:
          cfg_r.kp_gain <= cfg_wdata[cccvpi_pkg::GAIN_W-1:0];
        cccvpi_pkg::CFG_IDX_KI_T_GAIN:
          cfg_r.ki_t_gain <= cfg_wdata[cccvpi_pkg::GAIN_W-1:0];
        cccvpi_pkg::CFG_IDX_DRIVE_MAX:
          cfg_r.drive_max <= signed'(cfg_wdata[cccvpi_pkg::DRIVE_W-1:0]);
        cccvpi_pkg::CFG_IDX_DRIVE_MIN:
          cfg_r.drive_min <= signed'(cfg_wdata[cccvpi_pkg::DRIVE_W-1:0]);
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // input register: data loads on every accepted transfer, else holds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      isamp_r <= in_tdata[SB-1:0];
      vsamp_r <= in_tdata[2*SB-1:SB];
      en_r    <= in_tdata[2*SB];
    end
  end

  cccvpi_datapath u_datapath (
    .cfg       (cfg_r),
    .mode_cur  (mode_r),
    .integ_cur (integ_r),
    .drive_cur (last_drive_r),
    .isamp     (isamp_r),
    .vsamp     (vsamp_r),
    .en        (en_r),
    .mode_new  (mode_nxt),
    .integ_new (integ_nxt),
    .drive_new (drive_nxt)
  );

  // advance loop state together with the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= cccvpi_pkg::MODE_IDLE;
      integ_r      <= '0;
      last_drive_r <= '0;
    end else if (step) begin
      mode_r       <= mode_nxt;
      integ_r      <= integ_nxt;
      last_drive_r <= drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_drive_r <= drive_nxt;
      out_mode_r  <= mode_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(cccvpi_pkg::OUT_TDATA_W - cccvpi_pkg::DRIVE_W - cccvpi_pkg::MODE_W){1'b0}},
                       out_mode_r, out_drive_r};

endmodule

/* rtl/core/cccvpi_checker.sv */
// Port-level checker for the CC/CV charger regulator, bound to the top level.
// Depends on cccvpi_pkg and cc_cv_charger_pi_regulator_macros.svh.
`include "cc_cv_charger_pi_regulator_macros.svh"

module cccvpi_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [cccvpi_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  // last delivered result; reset state equals idle with zero drive
  logic [cccvpi_pkg::DRIVE_W-1:0] last_drive_r;
  logic [cccvpi_pkg::MODE_W-1:0]  last_mode_r;
  logic                           last_idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_drive_r <= '0;
      last_mode_r  <= cccvpi_pkg::MODE_IDLE;
    end else if (out_tvalid && out_tready) begin
      last_drive_r <= out_tdata[cccvpi_pkg::DRIVE_W-1:0];
      last_mode_r  <= out_tdata[cccvpi_pkg::DRIVE_W +: cccvpi_pkg::MODE_W];
    end
  end

  assign last_idle = (last_mode_r == cccvpi_pkg::MODE_IDLE);

  `CCCVPI_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result valid right after reset")
  `CCCVPI_ASSERT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `CCCVPI_ASSERT(a_idle_holds_drive, clk, rst_n, out_tvalid && last_idle |-> out_tdata[cccvpi_pkg::DRIVE_W-1:0] == last_drive_r, "drive moved on a step from idle")
  `CCCVPI_ASSERT(a_idle_not_to_cv, clk, rst_n, out_tvalid && last_idle |-> out_tdata[cccvpi_pkg::DRIVE_W +: cccvpi_pkg::MODE_W] != cccvpi_pkg::MODE_CV, "idle jumped straight to constant voltage")

endmodule

bind cc_cv_charger_pi_regulator cccvpi_checker u_cccvpi_checker (.*);
